FILE: sv/mono_framebuffer_serial_refresh_core_assert.svh
// Assertion macros, clocked on clock and disabled during reset
`ifndef MONO_FRAMEBUFFER_SERIAL_REFRESH_CORE_ASSERT_SVH
`define MONO_FRAMEBUFFER_SERIAL_REFRESH_CORE_ASSERT_SVH

// same-cycle implication
`define MFSR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MFSR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/mfsr_pkg.sv
package mfsr_pkg;

   localparam int ScreenWidth  = 128;
   localparam int ScreenHeight = 64;
   localparam int RowBytes     = ScreenWidth / 8;
   localparam int StoreBytes   = RowBytes * ScreenHeight;
   localparam int AddrW        = $clog2(StoreBytes);
   localparam int HalfRows     = ScreenHeight / 2;
   localparam int RowW         = $clog2(HalfRows);
   localparam int ColW         = $clog2(RowBytes);
   localparam int PerRow       = 2 + 2 * RowBytes;
   localparam int KW           = $clog2(PerRow);
   localparam int XW           = $clog2(ScreenWidth);
   localparam int YW           = $clog2(ScreenHeight);
   localparam int CoordW       = 11;

   localparam logic [7:0] SYNC_CMD     = 8'hF8;
   localparam logic [7:0] SYNC_DAT     = 8'hFA;
   localparam logic [7:0] NIB_MASK     = 8'hF0;
   localparam logic [7:0] ROW_CMD_BASE = 8'h80;
   localparam logic [7:0] TAIL_CMD     = 8'h30;

   typedef logic [1:0] opcode_type;
   localparam opcode_type OP_WRITE   = 2'd0;
   localparam opcode_type OP_READ    = 2'd1;
   localparam opcode_type OP_REFRESH = 2'd2;

   typedef logic [1:0] wmode_type;
   localparam wmode_type MODE_CLEAR = 2'd0;
   localparam wmode_type MODE_SET   = 2'd1;

   typedef logic [2:0] csr_index_type;
   localparam csr_index_type CSR_VIEW_EN     = 3'd0;
   localparam csr_index_type CSR_VIEW_LEFT   = 3'd1;
   localparam csr_index_type CSR_VIEW_RIGHT  = 3'd2;
   localparam csr_index_type CSR_VIEW_TOP    = 3'd3;
   localparam csr_index_type CSR_VIEW_BOTTOM = 3'd4;
   localparam csr_index_type CSR_GRAPHIC_CMD = 3'd5;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_RUN   = 4'b0010,
      ST_BEAT1 = 4'b0100,
      ST_BEAT2 = 4'b1000
   } state_type;

   typedef enum logic [2:0] {
      PH_HEAD = 3'b001,
      PH_BODY = 3'b010,
      PH_TAIL = 3'b100
   } phase_type;

   // what a refresh transfer carries
   typedef enum logic [2:0] {
      RK_HEAD = 3'd0,
      RK_ROW  = 3'd1,
      RK_HOME = 3'd2,
      RK_DATA = 3'd3,
      RK_TAIL = 3'd4
   } rkind_type;

endpackage

FILE: sv/mono_framebuffer_serial_refresh_core.sv
// Channel   Handshake              Beat
// req       start / busy           opcode, pos_x, pos_y, write_mode
// rsp       rsp_strobe             kind, pixel, serial byte, last, done, dirty
// csr       csr_write_en           csr_index, csr_wdata
//
// Pixel writes and reads never raise busy; a read answer passes the first stage and the result register.
// A refresh step holds busy in the first stage and in ST_BEAT1, and emits its three bytes on consecutive cycles.
// After reset the 1024-byte store is swept to zero, one byte a cycle, with busy high throughout.
// Result beats cannot be held off; each stands for exactly one cycle.
module mono_framebuffer_serial_refresh_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  mfsr_pkg::opcode_type        req_opcode,
   input  logic signed [10:0]          req_pos_x,
   input  logic signed [10:0]          req_pos_y,
   input  mfsr_pkg::wmode_type         req_write_mode,
   input  logic                        csr_write_en,
   input  mfsr_pkg::csr_index_type     csr_index,
   input  logic [7:0]                  csr_wdata,
   output logic                        rsp_strobe,
   output logic                        rsp_result_kind,
   output logic                        rsp_pixel_value,
   output logic [7:0]                  rsp_serial_byte,
   output logic                        rsp_last_of_run,
   output logic                        rsp_frame_done,
   output logic                        rsp_buffer_dirty
);
   import mfsr_pkg::*;

   `include "mono_framebuffer_serial_refresh_core_assert.svh"

   state_type            state_ff, state_in;
   logic [AddrW-1:0]     clr_ff, clr_in;
   phase_type            phase_ff, phase_in;
   logic [RowW-1:0]      row_ff, row_in;
   logic [KW-1:0]        k_ff, k_in;
   logic                 dirty_ff, dirty_in;

   logic                 view_en_ff, view_en_in;
   logic [XW-1:0]        view_left_ff, view_left_in;
   logic [XW-1:0]        view_right_ff, view_right_in;
   logic [YW-1:0]        view_top_ff, view_top_in;
   logic [YW-1:0]        view_bottom_ff, view_bottom_in;
   logic [7:0]           graphic_cmd_ff, graphic_cmd_in;

   logic                 s1_valid_ff, s1_valid_in;
   opcode_type           s1_op_ff;
   logic                 s1_hit_ff, s1_hit_in;
   logic [AddrW-1:0]     s1_addr_ff;
   logic [2:0]           s1_bit_ff;
   wmode_type            s1_mode_ff;
   rkind_type            s1_rkind_ff, s1_rkind_in;
   logic [RowW-1:0]      s1_row_ff;
   logic                 fwd_hit_ff, fwd_hit_in;
   logic [7:0]           fwd_data_ff;
   logic [7:0]           rd_ff;

   logic                 rsp_strobe_ff, rsp_strobe_in;
   logic                 rsp_kind_ff, rsp_kind_in;
   logic                 rsp_pixel_ff, rsp_pixel_in;
   logic [7:0]           rsp_byte_ff, rsp_byte_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_done_ff, rsp_done_in;
   logic                 rsp_dirty_ff;
   logic [7:0]           hold_val_ff, hold_val_in;
   logic                 hold_done_ff, hold_done_in;

   logic [7:0]           frame_mem [StoreBytes];

   logic                 accept;
   logic                 x_on, y_on, in_view;
   logic [XW-1:0]        px;
   logic [YW-1:0]        py;
   logic [AddrW-1:0]     pix_addr, ref_addr, acc_addr;
   logic [KW-1:0]        k_lo;
   logic                 half;
   logic                 clearing;
   logic [7:0]           cur_byte, bit_mask, new_byte;
   logic                 s1_write, s1_read, s1_refresh;
   logic                 read_pix;
   logic [7:0]           ref_val, ref_sync;
   logic                 ref_done;
   logic                 mem_we;
   logic [AddrW-1:0]     mem_waddr;
   logic [7:0]           mem_wdata;

   assign clearing = (state_ff == ST_CLEAR);
   assign s1_write   = s1_valid_ff && (s1_op_ff == OP_WRITE) && s1_hit_ff;
   assign s1_read    = s1_valid_ff && (s1_op_ff == OP_READ);
   assign s1_refresh = s1_valid_ff && (s1_op_ff == OP_REFRESH);

   assign busy   = clearing || (state_ff == ST_BEAT1) || s1_refresh;
   assign accept = start && !busy;

   // decode of the incoming beat
   always_comb begin
      x_on     = (req_pos_x[CoordW-1:XW] == '0);
      y_on     = (req_pos_y[CoordW-1:YW] == '0);
      px       = req_pos_x[XW-1:0];
      py       = req_pos_y[YW-1:0];
      in_view  = !view_en_ff ||
                 (px >= view_left_ff && px <= view_right_ff &&
                  py >= view_top_ff && py <= view_bottom_ff);
      pix_addr = {py, px[XW-1:3]};
      k_lo     = k_ff - KW'(2);
      half     = (k_ff >= KW'(2 + RowBytes));
      ref_addr = {half, row_ff, k_lo[ColW-1:0]};
      acc_addr = (req_opcode == OP_REFRESH) ? ref_addr : pix_addr;
      s1_hit_in = x_on && y_on && ((req_opcode != OP_WRITE) || in_view);
      s1_valid_in = accept && ((req_opcode == OP_WRITE) || (req_opcode == OP_READ) ||
                               (req_opcode == OP_REFRESH));
      unique case (phase_ff)
         PH_HEAD: s1_rkind_in = RK_HEAD;
         PH_TAIL: s1_rkind_in = RK_TAIL;
         default: begin
            if (k_ff == '0) begin
               s1_rkind_in = RK_ROW;
            end else if (k_ff == KW'(1)) begin
               s1_rkind_in = RK_HOME;
            end else begin
               s1_rkind_in = RK_DATA;
            end
         end
      endcase
   end

   // refresh sequence position
   always_comb begin
      phase_in = phase_ff;
      row_in   = row_ff;
      k_in     = k_ff;
      if (accept && (req_opcode == OP_REFRESH)) begin
         unique case (phase_ff)
            PH_HEAD: begin
               phase_in = PH_BODY;
               row_in   = '0;
               k_in     = '0;
            end
            PH_TAIL: phase_in = PH_HEAD;
            default: begin
               if (k_ff == KW'(PerRow - 1)) begin
                  k_in = '0;
                  if (row_ff == RowW'(HalfRows - 1)) begin
                     phase_in = PH_TAIL;
                  end else begin
                     row_in = row_ff + RowW'(1);
                  end
               end else begin
                  k_in = k_ff + KW'(1);
               end
            end
         endcase
      end
   end

   // second stage: byte in hand
   always_comb begin
      cur_byte = fwd_hit_ff ? fwd_data_ff : rd_ff;
      bit_mask = 8'h80 >> s1_bit_ff;
      priority if (s1_mode_ff == MODE_CLEAR) begin
         new_byte = cur_byte & ~bit_mask;
      end else if (s1_mode_ff == MODE_SET) begin
         new_byte = cur_byte | bit_mask;
      end else begin
         new_byte = cur_byte ^ bit_mask;
      end
      read_pix = s1_hit_ff && cur_byte[3'd7 - s1_bit_ff];
      unique case (s1_rkind_ff)
         RK_HEAD: ref_val = graphic_cmd_ff;
         RK_ROW:  ref_val = ROW_CMD_BASE + 8'(s1_row_ff);
         RK_HOME: ref_val = ROW_CMD_BASE;
         RK_DATA: ref_val = cur_byte;
         RK_TAIL: ref_val = TAIL_CMD;
         default: ref_val = '0;
      endcase
      ref_sync   = (s1_rkind_ff == RK_DATA) ? SYNC_DAT : SYNC_CMD;
      ref_done   = (s1_rkind_ff == RK_TAIL);
      fwd_hit_in = s1_write && accept && (acc_addr == s1_addr_ff);
      dirty_in   = dirty_ff || s1_write;
      mem_we     = clearing || s1_write;
      mem_waddr  = clearing ? clr_ff : s1_addr_ff;
      mem_wdata  = clearing ? '0 : new_byte;
      clr_in     = clearing ? clr_ff + AddrW'(1) : clr_ff;
   end

   // beat sequencing and result register
   always_comb begin
      state_in      = state_ff;
      rsp_strobe_in = 1'b0;
      rsp_kind_in   = 1'b1;
      rsp_pixel_in  = 1'b0;
      rsp_byte_in   = '0;
      rsp_last_in   = 1'b0;
      rsp_done_in   = 1'b0;
      hold_val_in   = hold_val_ff;
      hold_done_in  = hold_done_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == '1) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (s1_read) begin
               rsp_strobe_in = 1'b1;
               rsp_kind_in   = 1'b0;
               rsp_pixel_in  = read_pix;
               rsp_last_in   = 1'b1;
            end else if (s1_refresh) begin
               rsp_strobe_in = 1'b1;
               rsp_byte_in   = ref_sync;
               rsp_done_in   = ref_done;
               hold_val_in   = ref_val;
               hold_done_in  = ref_done;
               state_in      = ST_BEAT1;
            end
         end
         ST_BEAT1: begin
            rsp_strobe_in = 1'b1;
            rsp_byte_in   = hold_val_ff & NIB_MASK;
            rsp_done_in   = hold_done_ff;
            state_in      = ST_BEAT2;
         end
         ST_BEAT2: begin
            rsp_strobe_in = 1'b1;
            rsp_byte_in   = {hold_val_ff[3:0], 4'b0000};
            rsp_done_in   = hold_done_ff;
            rsp_last_in   = 1'b1;
            state_in      = ST_RUN;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // configuration writes
   always_comb begin
      view_en_in     = view_en_ff;
      view_left_in   = view_left_ff;
      view_right_in  = view_right_ff;
      view_top_in    = view_top_ff;
      view_bottom_in = view_bottom_ff;
      graphic_cmd_in = graphic_cmd_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_VIEW_EN:     view_en_in     = csr_wdata[0];
            CSR_VIEW_LEFT:   view_left_in   = csr_wdata[XW-1:0];
            CSR_VIEW_RIGHT:  view_right_in  = csr_wdata[XW-1:0];
            CSR_VIEW_TOP:    view_top_in    = csr_wdata[YW-1:0];
            CSR_VIEW_BOTTOM: view_bottom_in = csr_wdata[YW-1:0];
            CSR_GRAPHIC_CMD: graphic_cmd_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_ff         <= '0;
         phase_ff       <= PH_HEAD;
         row_ff         <= '0;
         k_ff           <= '0;
         dirty_ff       <= 1'b0;
         view_en_ff     <= 1'b0;
         view_left_ff   <= '0;
         view_right_ff  <= XW'(ScreenWidth - 1);
         view_top_ff    <= '0;
         view_bottom_ff <= YW'(ScreenHeight - 1);
         graphic_cmd_ff <= 8'h36;
         s1_valid_ff    <= 1'b0;
         fwd_hit_ff     <= 1'b0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         phase_ff       <= phase_in;
         row_ff         <= row_in;
         k_ff           <= k_in;
         dirty_ff       <= dirty_in;
         view_en_ff     <= view_en_in;
         view_left_ff   <= view_left_in;
         view_right_ff  <= view_right_in;
         view_top_ff    <= view_top_in;
         view_bottom_ff <= view_bottom_in;
         graphic_cmd_ff <= graphic_cmd_in;
         s1_valid_ff    <= s1_valid_in;
         fwd_hit_ff     <= fwd_hit_in;
         rsp_strobe_ff  <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff     <= req_opcode;
      s1_hit_ff    <= s1_hit_in;
      s1_addr_ff   <= acc_addr;
      s1_bit_ff    <= px[2:0];
      s1_mode_ff   <= req_write_mode;
      s1_rkind_ff  <= s1_rkind_in;
      s1_row_ff    <= row_ff;
      fwd_data_ff  <= new_byte;
      hold_val_ff  <= hold_val_in;
      hold_done_ff <= hold_done_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_done_ff  <= rsp_done_in;
      rsp_dirty_ff <= dirty_ff;
   end

   // frame store, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= frame_mem[acc_addr];
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_result_kind  = rsp_kind_ff;
   assign rsp_pixel_value  = rsp_pixel_ff;
   assign rsp_serial_byte  = rsp_byte_ff;
   assign rsp_last_of_run  = rsp_last_ff;
   assign rsp_frame_done   = rsp_done_ff;
   assign rsp_buffer_dirty = rsp_dirty_ff;

   `MFSR_ASSERT_NOW(a_clear_busy, state_ff == ST_CLEAR, busy && !s1_valid_ff, "beat taken during clearing sweep")
   `MFSR_ASSERT_NEXT(a_refresh_busy, accept && (req_opcode == OP_REFRESH), busy, "refresh step not holding busy")
   `MFSR_ASSERT_NOW(a_three_beats, rsp_strobe && rsp_result_kind && rsp_last_of_run, $past(rsp_strobe, 1) && $past(rsp_strobe, 2), "serial transfer short of three beats")

endmodule
